### sv/e2q_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_pkg: shared types and constants of the Euler angle to quaternion block
// Holds the CORDIC arctangent table, the fixed-point widths and the lane types.
// ----------------------------------------------------------------------------
package e2q_pkg;

	localparam int RotationSteps = 16;
	localparam int AngleBits     = 16;
	localparam int AngleFrac     = AngleBits - 3;
	localparam int AtanEntries   = 24;
	localparam int Steps         = (RotationSteps > AtanEntries) ? AtanEntries : RotationSteps;
	localparam int TShift        = 30 - AngleFrac;
	localparam int ZW            = AngleBits + 2;
	localparam int XW            = 33;
	// A cosine of one rounds to 32768 in Q.15, so one bit above the 16 is kept.
	localparam int TW            = 17;
	localparam int PW            = 48;

	localparam logic signed [XW-1:0] Gain = 33'sd652032874;
	localparam logic signed [31:0] QuarterQ30 = 32'sd1686629713;
	localparam logic signed [ZW-1:0] Quarter = ZW'(QuarterQ30 >>> TShift);

	localparam logic signed [15:0] OneQ14 = 16'sd16384;

	typedef logic signed [14:0] angle_t;
	typedef logic signed [TW-1:0] trig_t;
	typedef logic signed [15:0] comp_t;
	typedef logic signed [ZW-1:0] zang_t;
	typedef logic signed [XW-1:0] vec_t;

	typedef struct packed {
		trig_t c;
		trig_t s;
	} cs_t;

	function automatic zang_t atan_at(input int i);
		logic [31:0] t;
		begin
			unique case (i)
				0: t = 32'h3243F6A8;
				1: t = 32'h1DAC6705;
				2: t = 32'h0FADBAFC;
				3: t = 32'h07F56EA6;
				4: t = 32'h03FEAB76;
				5: t = 32'h01FFD55B;
				6: t = 32'h00FFFAAA;
				7: t = 32'h007FFF55;
				8: t = 32'h003FFFEA;
				9: t = 32'h001FFFFD;
				10: t = 32'h000FFFFF;
				11: t = 32'h0007FFFF;
				12: t = 32'h0003FFFF;
				13: t = 32'h0001FFFF;
				14: t = 32'h0000FFFF;
				15: t = 32'h00007FFF;
				16: t = 32'h00003FFF;
				17: t = 32'h00001FFF;
				18: t = 32'h00000FFF;
				19: t = 32'h000007FF;
				20: t = 32'h000003FF;
				21: t = 32'h000001FF;
				22: t = 32'h000000FF;
				default: t = 32'h0000007F;
			endcase
			atan_at = ZW'(t >> TShift);
		end
	endfunction

endpackage
`default_nettype wire

### sv/euler_to_quaternion.sv
`default_nettype none
// ----------------------------------------------------------------------------
// euler_to_quaternion: Z-Y-X Euler angles to rotation quaternion
// Three CORDIC lanes find the half-angle cosines and sines; a merging stage
// forms the four components.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_axis    in         yaw, pitch, roll angles, Q3.12
// m_axis    out        x, y, z, w components, Q1.14
//
// One transaction is accepted every clock cycle unless the output stalls. The
// pipeline is the CORDIC depth (steps plus two) plus three merge stages; it
// advances only when the output register is empty or being taken, so a stall
// on the output side holds every stage. Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module euler_to_quaternion (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// yaw_angle [14:0], pitch_angle [29:15], roll_angle [44:30], zero fill
	input  wire  [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// quat_x [15:0], quat_y [31:16], quat_z [47:32], quat_w [63:48]
	output logic [63:0] m_axis_tdata
);
	import e2q_pkg::*;

	// Lane depth: start, Steps rotations, rounding; then three merge stages.
	localparam int Depth = Steps + 2 + 3;

	logic [Depth-1:0] vld_q;
	logic en;
	cs_t  cs_yaw, cs_pitch, cs_roll;
	comp_t qx, qy, qz, qw;

	// The pipeline moves when the last stage is empty or being taken.
	assign en = !vld_q[Depth-1] || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
		end
	end

	e2q_cordic u_yaw (.clk(clk), .en(en),
		.angle(s_axis_tdata[14:0]), .cs(cs_yaw));
	e2q_cordic u_pitch (.clk(clk), .en(en),
		.angle(s_axis_tdata[29:15]), .cs(cs_pitch));
	e2q_cordic u_roll (.clk(clk), .en(en),
		.angle(s_axis_tdata[44:30]), .cs(cs_roll));

	e2q_merge u_merge (.clk(clk), .en(en), .yaw(cs_yaw), .pitch(cs_pitch),
		.roll(cs_roll), .quat_x(qx), .quat_y(qy), .quat_z(qz), .quat_w(qw));

	assign m_axis_tvalid = vld_q[Depth-1];
	assign m_axis_tdata  = {qw, qz, qy, qx};
endmodule
`default_nettype wire

### sv/e2q_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_cordic: pipelined rotation-mode CORDIC lane
// Gives the rounded cosine and sine of half of one input angle.
// ----------------------------------------------------------------------------
module e2q_cordic (
	input  wire              clk,
	input  wire              en,
	input  e2q_pkg::angle_t  angle,
	output e2q_pkg::cs_t     cs
);
	import e2q_pkg::*;

	vec_t  x_q [Steps+1];
	vec_t  y_q [Steps+1];
	zang_t z_q [Steps+1];
	zang_t z0;

	// Halving the Q3.12 angle gives a half angle with 13 fraction bits.
	always_comb begin
		if (AngleFrac >= 13)
			z0 = zang_t'(angle) <<< (AngleFrac - 13);
		else
			z0 = zang_t'(angle) >>> (13 - AngleFrac);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (z0 > Quarter) begin
				x_q[0] <= '0;
				y_q[0] <= Gain;
				z_q[0] <= z0 - Quarter;
			end else if (z0 < -Quarter) begin
				x_q[0] <= '0;
				y_q[0] <= -Gain;
				z_q[0] <= z0 + Quarter;
			end else begin
				x_q[0] <= Gain;
				y_q[0] <= '0;
				z_q[0] <= z0;
			end
		end
	end

	for (genvar i = 0; i < Steps; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_q[i][ZW-1]) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - atan_at(i);
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + atan_at(i);
				end
			end
		end
	end

	vec_t xr, yr;
	assign xr = (x_q[Steps] + vec_t'(16384)) >>> 15;
	assign yr = (y_q[Steps] + vec_t'(16384)) >>> 15;

	always_ff @(posedge clk) begin
		if (en) begin
			cs.c <= xr[TW-1:0];
			cs.s <= yr[TW-1:0];
		end
	end
endmodule
`default_nettype wire

### sv/e2q_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_merge: combines the three lanes into the four quaternion components
// Two product stages, then the sums, rounding and saturation.
// ----------------------------------------------------------------------------
module e2q_merge (
	input  wire            clk,
	input  wire            en,
	input  e2q_pkg::cs_t   yaw,
	input  e2q_pkg::cs_t   pitch,
	input  e2q_pkg::cs_t   roll,
	output e2q_pkg::comp_t quat_x,
	output e2q_pkg::comp_t quat_y,
	output e2q_pkg::comp_t quat_z,
	output e2q_pkg::comp_t quat_w
);
	import e2q_pkg::*;

	logic signed [2*TW-1:0] cc_s1, ss_s1, cs_s1, sc_s1;
	trig_t cr_s1, sr_s1;
	logic signed [PW-1:0] ccc_s2, ccs_s2, csc_s2, css_s2, scc_s2, scs_s2, ssc_s2, sss_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			cc_s1 <= yaw.c * pitch.c;
			ss_s1 <= yaw.s * pitch.s;
			cs_s1 <= yaw.c * pitch.s;
			sc_s1 <= yaw.s * pitch.c;
			cr_s1 <= roll.c;
			sr_s1 <= roll.s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ccc_s2 <= PW'(cc_s1) * PW'(cr_s1);
			ccs_s2 <= PW'(cc_s1) * PW'(sr_s1);
			csc_s2 <= PW'(cs_s1) * PW'(cr_s1);
			css_s2 <= PW'(cs_s1) * PW'(sr_s1);
			scc_s2 <= PW'(sc_s1) * PW'(cr_s1);
			scs_s2 <= PW'(sc_s1) * PW'(sr_s1);
			ssc_s2 <= PW'(ss_s1) * PW'(cr_s1);
			sss_s2 <= PW'(ss_s1) * PW'(sr_s1);
		end
	end

	function automatic comp_t sat(input logic signed [PW:0] v);
		logic signed [PW:0] r;
		begin
			r = (v + (PW+1)'(64'sh4000_0000)) >>> 31;
			if (r > (PW+1)'(OneQ14))
				sat = OneQ14;
			else if (r < -(PW+1)'(OneQ14))
				sat = -OneQ14;
			else
				sat = r[15:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			quat_x <= sat((PW+1)'(ccs_s2) - (PW+1)'(ssc_s2));
			quat_y <= sat((PW+1)'(csc_s2) + (PW+1)'(scs_s2));
			quat_z <= sat((PW+1)'(scc_s2) - (PW+1)'(css_s2));
			quat_w <= sat((PW+1)'(ccc_s2) + (PW+1)'(sss_s2));
		end
	end
endmodule
`default_nettype wire

### sv/e2q_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_checker: port-level checks of the quaternion converter
// Watches the handshakes and the range of the w result.
// ----------------------------------------------------------------------------
module e2q_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [63:0] m_axis_tdata
);
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed during stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid || m_axis_tready |-> s_axis_tready)
		else $error("input stalled with free output");
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output blocked");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $signed(m_axis_tdata[63:48]) <= 16384
			&& $signed(m_axis_tdata[63:48]) >= -16384)
		else $error("w out of range");
endmodule

bind euler_to_quaternion e2q_checker u_chk (.clk(clk), .arst_n(arst_n),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata));
`default_nettype wire

### bench/euler_to_quaternion_test.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion_test: self-checking bench of the Euler to quaternion block
// Drives angle triples with random gaps, stalls the output side at random and
// compares every output transaction with a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module euler_to_quaternion_test;
	import e2q_pkg::*;

	localparam int CycleLimit  = 200000;
	localparam int RandomItems = 900;
	// Pipeline depth is the CORDIC depth plus three merge stages.
	localparam int Latency     = RotationSteps + 2 + 3;

	typedef struct packed {
		comp_t w;
		comp_t z;
		comp_t y;
		comp_t x;
	} quat_t;

	typedef struct {
		angle_t yaw;
		angle_t pitch;
		angle_t roll;
		bit     known;
		quat_t  q;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;

	quat_t expected_quats[$];
	int    errors;
	int    cycles;
	int    sent;
	int    received;
	int    saturated;
	bit    stim_done;

	euler_to_quaternion u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Arithmetic shift right rounding towards minus infinity.
	function automatic longint floor_shift(input longint v, input int s);
		floor_shift = v >>> s;
	endfunction

	function automatic longint atan_entry(input int i);
		longint t[24];
		t = '{'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
			'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
			'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
			'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F};
		atan_entry = t[i];
	endfunction

	// Cosine and sine (Q.15) of half of a Q3.12 angle by rotation CORDIC.
	task automatic half_angle_trig(input angle_t a, output longint c, output longint s);
		longint z, x, y, dx, dy, quarter;
		int sh, tsh, n;
		sh = AngleFrac - 13;
		tsh = 30 - AngleFrac;
		quarter = longint'(1686629713) >>> tsh;
		if (sh >= 0)
			z = longint'(a) <<< sh;
		else
			z = floor_shift(longint'(a), -sh);
		// Half angles beyond a quarter turn start from a pre-rotated vector.
		if (z > quarter) begin
			x = 0; y = 652032874; z = z - quarter;
		end else if (z < -quarter) begin
			x = 0; y = -652032874; z = z + quarter;
		end else begin
			x = 652032874; y = 0;
		end
		n = (RotationSteps > 24) ? 24 : RotationSteps;
		for (int i = 0; i < n; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_entry(i) >>> tsh;
			end else begin
				x += dx; y -= dy; z += atan_entry(i) >>> tsh;
			end
		end
		c = floor_shift(x + (longint'(1) << 14), 15);
		s = floor_shift(y + (longint'(1) << 14), 15);
	endtask

	function automatic comp_t round_saturate(input longint sum);
		longint r;
		r = floor_shift(sum + (longint'(1) << 30), 31);
		if (r > 16384) r = 16384;
		if (r < -16384) r = -16384;
		round_saturate = comp_t'(r);
	endfunction

	task automatic predict_quat(input angle_t yaw, input angle_t pitch, input angle_t roll,
			output quat_t q);
		longint cy, sy, cp, sp, cr, sr;
		half_angle_trig(yaw, cy, sy);
		half_angle_trig(pitch, cp, sp);
		half_angle_trig(roll, cr, sr);
		q.x = round_saturate(cy * cp * sr - sy * sp * cr);
		q.y = round_saturate(cy * sp * cr + sy * cp * sr);
		q.z = round_saturate(sy * cp * cr - cy * sp * sr);
		q.w = round_saturate(cy * cp * cr + sy * sp * sr);
	endtask

	// Sends one angle triple after a random gap and queues its expected quaternion.
	// Called at a falling edge; valid stays high between triples sent with no gap.
	task automatic send_angles(input angle_t yaw, input angle_t pitch, input angle_t roll,
			input bit known, input quat_t typed_q);
		quat_t q;
		int gap;
		predict_quat(yaw, pitch, roll, q);
		if (known && q !== typed_q) begin
			$display("%0t: predictor disagrees with table row: expected %h actual %h",
				$time, typed_q, q);
			errors++;
		end
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  <= {3'b000, roll, pitch, yaw};
		s_axis_tvalid <= 1'b1;
		expected_quats.push_back(known ? typed_q : q);
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	// Directed rows: zero angles, field limits, quarter-turn boundaries and mixtures.
	row_t rows[] = '{
		'{15'sd0, 15'sd0, 15'sd0, 1'b0, '0},
		'{15'sh4000, 15'sd0, 15'sd0, 1'b0, '0},
		'{15'sd16383, 15'sd0, 15'sd0, 1'b0, '0},
		'{15'sd0, 15'sh4000, 15'sd0, 1'b0, '0},
		'{15'sd0, 15'sd16383, 15'sd0, 1'b0, '0},
		'{15'sd0, 15'sd0, 15'sh4000, 1'b0, '0},
		'{15'sd0, 15'sd0, 15'sd16383, 1'b0, '0},
		'{15'sd16383, 15'sd16383, 15'sd16383, 1'b0, '0},
		'{15'sh4000, 15'sh4000, 15'sh4000, 1'b0, '0},
		'{15'sd12868, 15'sd12868, 15'sd12868, 1'b0, '0},
		'{15'sd12869, -15'sd12869, 15'sd12867, 1'b0, '0},
		'{-15'sd12868, 15'sd6434, -15'sd6434, 1'b0, '0},
		'{15'sd6434, 15'sd0, 15'sd0, 1'b0, '0},
		'{15'sd0, 15'sd6434, 15'sd0, 1'b0, '0},
		'{15'sd1, -15'sd1, 15'sd1, 1'b0, '0},
		'{15'sd10922, -15'sd21, 15'sd4096, 1'b0, '0},
		'{15'h2AAA, 15'h5555, 15'h7FFF, 1'b0, '0},
		'{15'h5555, 15'h2AAA, 15'h0000, 1'b0, '0}
	};

	initial begin : stimulus
		angle_t a[3];
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		errors = 0; sent = 0; stim_done = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (rows[i])
			send_angles(rows[i].yaw, rows[i].pitch, rows[i].roll, rows[i].known, rows[i].q);
		for (int n = 0; n < RandomItems; n++) begin
			// Mostly full-range angles, with some near zero and some at the limits.
			for (int k = 0; k < 3; k++) begin
				case ($urandom_range(0, 7))
					0: a[k] = angle_t'($urandom_range(0, 64) - 32);
					1: a[k] = $urandom_range(0, 1) ? 15'sh3FFF : 15'sh4000;
					default: a[k] = angle_t'($urandom);
				endcase
			end
			send_angles(a[0], a[1], a[2], 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;
		stim_done = 1;
	end

	// Output side: random stall before each result, with stretches of none.
	initial begin : sink
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	// Scoreboard: every output transaction against the oldest expectation.
	always @(posedge clk) begin : scoreboard
		quat_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			received++;
			if (expected_quats.size() == 0) begin
				$display("%0t: unexpected output: expected none actual %h", $time, got);
				errors++;
			end else begin
				want = expected_quats.pop_front();
				if (got.x !== want.x) begin
					$display("%0t: quat_x expected %0d actual %0d", $time, want.x, got.x);
					errors++;
				end
				if (got.y !== want.y) begin
					$display("%0t: quat_y expected %0d actual %0d", $time, want.y, got.y);
					errors++;
				end
				if (got.z !== want.z) begin
					$display("%0t: quat_z expected %0d actual %0d", $time, want.z, got.z);
					errors++;
				end
				if (got.w !== want.w) begin
					$display("%0t: quat_w expected %0d actual %0d", $time, want.w, got.w);
					errors++;
				end
				if (want.w == 16384 || want.x == 16384 || want.y == 16384 || want.z == 16384)
					saturated++;
			end
		end
	end

	initial begin : watchdog
		cycles = 0; received = 0; saturated = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CycleLimit) begin
				$display("timeout after %0d cycles, %0d results outstanding",
					cycles, expected_quats.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// The run ends once stimulus is done and every expected result has arrived.
	initial begin : finisher
		wait (stim_done);
		while (expected_quats.size() != 0) @(posedge clk);
		repeat (Latency + 4) @(posedge clk);
		if (expected_quats.size() != 0) errors++;
		$display("Covered %0d angle triples and %0d quaternions, %0d at the unit limit.",
			sent, received, saturated);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### euler_to_quaternion.f
sv/e2q_pkg.sv
sv/e2q_cordic.sv
sv/e2q_merge.sv
sv/euler_to_quaternion.sv
sv/e2q_checker.sv
bench/euler_to_quaternion_test.sv
